// ----- design/bc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the BC1/BC2/BC3 block decoder.
`default_nettype none

package bc_pkg;

	localparam int BC_MAX_DIM = 4096;
	localparam int BC_CFG_W   = 13;
	localparam int BC_ADDR_W  = 3;

	// Block formats; the unused code decodes as DXT5.
	localparam logic [1:0] MODE_DXT1 = 2'd0;
	localparam logic [1:0] MODE_DXT3 = 2'd1;

	// Register indexes, taken from paddr[2].
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [9:0]  block_col;
		logic [9:0]  block_row;
		logic [63:0] alpha_word;
		logic [63:0] color_word;
	} bc_blk_t;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [31:0] texel_0;
		logic [31:0] texel_1;
		logic [31:0] texel_2;
		logic [31:0] texel_3;
		logic [3:0]  write_mask;
		logic        last_row;
	} bc_row_t;

	// Color entries hold {B, G, R}; transp marks entry 3 as transparent black.
	typedef struct packed {
		logic [3:0][23:0] color;
		logic             transp;
		logic [7:0][7:0]  alut;
	} bc_pal_t;

	function automatic logic [7:0] exp5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] exp6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	// Division by constants through reciprocal multiplication, exact over the input range.
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [19:0] p;
		p = 20'(x) * 20'd683;
		return p[18:11];
	endfunction

	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'd2341;
		return p[21:14];
	endfunction

	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'd3277;
		return p[21:14];
	endfunction

endpackage

`default_nettype wire

// ----- design/bc1_bc2_bc3_block_decoder.sv -----
// Top level of the BC1/BC2/BC3 block decoder: handshake, row sequencing, lanes and row merge.
//
//   channel  | handshake            | payload    | notes
//   blk      | blk_valid, blk_stall | blk_data   | one compressed 4x4 block per request
//   row      | row_valid, row_stall | row_data   | four row results per block, top row first
//   apb      | psel, penable, ...   | pwdata     | image_width at 0x0, image_height at 0x4
//
// An accepted block is registered in the sums stage, then the palette/row stage, and each row in
// the output register; rows follow one per cycle unless row_stall holds them. The row stage holds
// one palette while the next block waits in the sums stage and moves up as the fourth row leaves.
// Reset clears all valid flags and sets both image dimensions to 4.
// A stall on the row channel holds the output register and backs up into blk_stall.
`default_nettype none

module bc1_bc2_bc3_block_decoder
	import bc_pkg::*;
#(
	parameter int MAX_DIM = BC_MAX_DIM
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 blk_valid,
	output logic                      blk_stall,
	input  wire bc_blk_t              blk_data,
	output logic                      row_valid,
	input  wire logic                 row_stall,
	output bc_row_t                   row_data,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [BC_ADDR_W-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready
);

	localparam int DimW = ($clog2(MAX_DIM + 1) > BC_CFG_W) ? $clog2(MAX_DIM + 1) : BC_CFG_W;

	logic [BC_CFG_W-1:0] width_q, height_q;
	logic [DimW-1:0]     w_eff, h_eff;

	logic v1_q, v2_q, out_valid_q;
	logic [1:0] row_cnt_q;
	logic out_free, emit, rel2, adv, accept;

	logic [1:0]  mode_s1, mode_s2;
	logic [9:0]  col_s1, col_s2, brow_s1, brow_s2;
	logic [63:0] aw_s1, aw_s2;
	logic [31:0] cidx_s1, cidx_s2;

	bc_pal_t pal;

	logic [3:0][7:0]  cidx_rows;
	logic [3:0][15:0] nib_rows;
	logic [3:0][11:0] aidx_rows;
	logic [7:0]       cidx_row;
	logic [15:0]      nib_row;
	logic [11:0]      aidx_row;
	logic [3:0][31:0] texel;
	logic [3:0]       mask;
	logic [11:0]      px, py;
	bc_row_t          row_d, out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= BC_CFG_W'(4);
			height_q <= BC_CFG_W'(4);
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[BC_CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[BC_CFG_W-1:0];
				default:    ;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

	assign w_eff = (DimW'(width_q) > DimW'(MAX_DIM)) ? DimW'(MAX_DIM) : DimW'(width_q);
	assign h_eff = (DimW'(height_q) > DimW'(MAX_DIM)) ? DimW'(MAX_DIM) : DimW'(height_q);

	// Pipeline control: sums stage, palette/row stage, output register.
	assign out_free  = !out_valid_q || !row_stall;
	assign emit      = v2_q && out_free;
	assign rel2      = emit && (row_cnt_q == 2'd3);
	assign adv       = v1_q && (!v2_q || rel2);
	assign blk_stall = v1_q && !adv;
	assign accept    = blk_valid && !blk_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			row_cnt_q   <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			v1_q        <= accept || (v1_q && !adv);
			v2_q        <= adv || (v2_q && !rel2);
			out_valid_q <= emit || (out_valid_q && row_stall);
			if (adv) begin
				row_cnt_q <= 2'd0;
			end else if (emit) begin
				row_cnt_q <= row_cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= blk_data.mode;
			col_s1  <= blk_data.block_col;
			brow_s1 <= blk_data.block_row;
			aw_s1   <= blk_data.alpha_word;
			cidx_s1 <= blk_data.color_word[63:32];
		end
		if (adv) begin
			mode_s2 <= mode_s1;
			col_s2  <= col_s1;
			brow_s2 <= brow_s1;
			aw_s2   <= aw_s1;
			cidx_s2 <= cidx_s1;
		end
		if (emit) begin
			out_q <= row_d;
		end
	end

	bc_palette u_palette (
		.clk        (clk),
		.load_s1    (accept),
		.load_s2    (adv),
		.mode       (blk_data.mode),
		.alpha_ends (blk_data.alpha_word[15:0]),
		.color_ends (blk_data.color_word[31:0]),
		.pal        (pal)
	);

	assign cidx_rows = cidx_s2;
	assign nib_rows  = aw_s2;
	assign aidx_rows = aw_s2[63:16];
	assign cidx_row  = cidx_rows[row_cnt_q];
	assign nib_row   = nib_rows[row_cnt_q];
	assign aidx_row  = aidx_rows[row_cnt_q];

	assign px = {col_s2, 2'b00};
	assign py = {brow_s2, row_cnt_q};

	for (genvar k = 0; k < 4; k++) begin : g_lane
		bc_lane u_lane (
			.pal   (pal),
			.mode  (mode_s2),
			.sel   (cidx_row[2*k +: 2]),
			.nib   (nib_row[4*k +: 4]),
			.aidx  (aidx_row[3*k +: 3]),
			.texel (texel[k])
		);
		assign mask[k] = ((DimW'(px) + DimW'(k)) < w_eff) && (DimW'(py) < h_eff);
	end

	// Merge the four lanes into one row result.
	always_comb begin
		row_d.pixel_x    = px;
		row_d.pixel_y    = py;
		row_d.texel_0    = texel[0];
		row_d.texel_1    = texel[1];
		row_d.texel_2    = texel[2];
		row_d.texel_3    = texel[3];
		row_d.write_mask = mask;
		row_d.last_row   = (row_cnt_q == 2'd3);
	end

	assign row_valid = out_valid_q;
	assign row_data  = out_q;

`ifndef NO_ASSERTIONS
	a_row_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!v2_q |-> row_cnt_q == 2'd0)
		else $error("row counter moved without a block in the row stage");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> row_data.last_row == (row_data.pixel_y[1:0] == 2'b11))
		else $error("last_row does not match the row position");

	a_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_q |-> !blk_stall)
		else $error("block request stalled with an empty sums stage");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		rel2 && !adv |=> !v2_q)
		else $error("row stage still valid after its fourth row left");
`endif

endmodule

`default_nettype wire

// ----- design/bc_palette.sv -----
// Two-stage palette builder: weighted sums in the first stage, constant division in the second.
`default_nettype none

module bc_palette
	import bc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        load_s1,
	input  wire logic        load_s2,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] alpha_ends,
	input  wire logic [31:0] color_ends,
	output bc_pal_t          pal
);

	logic [2:0][7:0]  e0, e1;
	logic [2:0][9:0]  suma, sumb;
	logic [2:0][7:0]  mid;
	logic             interp3;
	logic             agt;
	logic [5:0][10:0] asum;

	logic [2:0][7:0]  e0_s1, e1_s1, mid_s1;
	logic [2:0][9:0]  suma_s1, sumb_s1;
	logic             interp3_s1, agt_s1;
	logic [7:0]       a0_s1, a1_s1;
	logic [5:0][10:0] asum_s1;

	bc_pal_t pal_d;
	bc_pal_t pal_s2;

	always_comb begin
		e0[0] = exp5(color_ends[15:11]);
		e0[1] = exp6(color_ends[10:5]);
		e0[2] = exp5(color_ends[4:0]);
		e1[0] = exp5(color_ends[31:27]);
		e1[1] = exp6(color_ends[26:21]);
		e1[2] = exp5(color_ends[20:16]);
		interp3 = (mode != MODE_DXT1) || (color_ends[15:0] > color_ends[31:16]);
		for (int ch = 0; ch < 3; ch++) begin
			suma[ch] = {1'b0, e0[ch], 1'b0} + 10'(e1[ch]);
			sumb[ch] = 10'(e0[ch]) + {1'b0, e1[ch], 1'b0};
			mid[ch]  = 8'((9'(e0[ch]) + 9'(e1[ch])) >> 1);
		end
		agt = alpha_ends[7:0] > alpha_ends[15:8];
		for (int i = 0; i < 6; i++) begin
			if (agt) begin
				asum[i] = 11'(alpha_ends[7:0]) * 11'(6 - i) + 11'(alpha_ends[15:8]) * 11'(i + 1);
			end else if (i < 4) begin
				asum[i] = 11'(alpha_ends[7:0]) * 11'(4 - i) + 11'(alpha_ends[15:8]) * 11'(i + 1);
			end else begin
				asum[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			e0_s1      <= e0;
			e1_s1      <= e1;
			mid_s1     <= mid;
			suma_s1    <= suma;
			sumb_s1    <= sumb;
			interp3_s1 <= interp3;
			agt_s1     <= agt;
			a0_s1      <= alpha_ends[7:0];
			a1_s1      <= alpha_ends[15:8];
			asum_s1    <= asum;
		end
	end

	always_comb begin
		pal_d.color[0] = {e0_s1[2], e0_s1[1], e0_s1[0]};
		pal_d.color[1] = {e1_s1[2], e1_s1[1], e1_s1[0]};
		for (int ch = 0; ch < 3; ch++) begin
			pal_d.color[2][8*ch +: 8] = interp3_s1 ? div3(suma_s1[ch]) : mid_s1[ch];
			pal_d.color[3][8*ch +: 8] = interp3_s1 ? div3(sumb_s1[ch]) : 8'h00;
		end
		pal_d.transp  = !interp3_s1;
		pal_d.alut[0] = a0_s1;
		pal_d.alut[1] = a1_s1;
		for (int i = 0; i < 6; i++) begin
			if (agt_s1) begin
				pal_d.alut[2 + i] = div7(asum_s1[i]);
			end else if (i < 4) begin
				pal_d.alut[2 + i] = div5(asum_s1[i]);
			end else if (i == 4) begin
				pal_d.alut[2 + i] = 8'h00;
			end else begin
				pal_d.alut[2 + i] = 8'hFF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			pal_s2 <= pal_d;
		end
	end

	assign pal = pal_s2;

endmodule

`default_nettype wire

// ----- design/bc_lane.sv -----
// One texel lane: palette lookup and alpha selection for a single pixel of a row.
`default_nettype none

module bc_lane
	import bc_pkg::*;
(
	input  wire bc_pal_t     pal,
	input  wire logic [1:0]  mode,
	input  wire logic [1:0]  sel,
	input  wire logic [3:0]  nib,
	input  wire logic [2:0]  aidx,
	output logic      [31:0] texel
);

	logic [7:0] alpha;

	always_comb begin
		case (mode)
			MODE_DXT1: alpha = (pal.transp && sel == 2'd3) ? 8'h00 : 8'hFF;
			MODE_DXT3: alpha = {nib, nib};
			default:   alpha = pal.alut[aidx];
		endcase
		texel = {alpha, pal.color[sel]};
	end

endmodule

`default_nettype wire

// ----- test/bc1_bc2_bc3_block_decoder_tb.sv -----
// Self-checking testbench for the BC1/BC2/BC3 block decoder with its own block decode model.
`default_nettype none

module bc1_bc2_bc3_block_decoder_tb;
	import bc_pkg::*;

	localparam logic [1:0] MODE_DXT5  = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	// Decodes each accepted block into its four expected rows and matches rows in order.
	class texel_row_tracker;
		bc_row_t rows_due[$];
		int unsigned img_w = 4;
		int unsigned img_h = 4;
		int errors = 0;

		function void set_dim(logic idx, logic [31:0] val);
			if (idx == REG_WIDTH) begin
				img_w = val[BC_CFG_W-1:0];
			end else begin
				img_h = val[BC_CFG_W-1:0];
			end
		endfunction

		function int unsigned widen(int unsigned v, int unsigned bits);
			return ((v << (8 - bits)) | (v >> (2 * bits - 8))) & 8'hFF;
		endfunction

		function int pending();
			return rows_due.size();
		endfunction

		function void add_block(bc_blk_t b);
			int unsigned c0, c1, cv, w, h, px, py, sel, a, a0, a1, mask, t;
			int unsigned pal[4][3];
			int unsigned alut[8];
			int e, ch, i, r, k;
			bit punch;
			logic [31:0] tx[4];
			bc_row_t row;
			c0 = b.color_word[15:0];
			c1 = b.color_word[31:16];
			for (e = 0; e < 2; e++) begin
				cv = (e == 0) ? c0 : c1;
				pal[e][0] = widen((cv >> 11) & 5'h1F, 5);
				pal[e][1] = widen((cv >> 5) & 6'h3F, 6);
				pal[e][2] = widen(cv & 5'h1F, 5);
			end
			// Only DXT1 with c0 not above c1 switches to the three-color palette.
			punch = (b.mode == MODE_DXT1) && (c0 <= c1);
			for (ch = 0; ch < 3; ch++) begin
				if (!punch) begin
					pal[2][ch] = (2 * pal[0][ch] + pal[1][ch]) / 3;
					pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch]) / 3;
				end else begin
					pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
					pal[3][ch] = 0;
				end
			end
			a0 = b.alpha_word[7:0];
			a1 = b.alpha_word[15:8];
			alut[0] = a0;
			alut[1] = a1;
			if (a0 > a1) begin
				for (i = 0; i < 6; i++)
					alut[2 + i] = ((6 - i) * a0 + (i + 1) * a1) / 7;
			end else begin
				for (i = 0; i < 4; i++)
					alut[2 + i] = ((4 - i) * a0 + (i + 1) * a1) / 5;
				alut[6] = 0;
				alut[7] = 8'hFF;
			end
			w = (img_w > BC_MAX_DIM) ? BC_MAX_DIM : img_w;
			h = (img_h > BC_MAX_DIM) ? BC_MAX_DIM : img_h;
			px = b.block_col * 4;
			for (r = 0; r < 4; r++) begin
				py = b.block_row * 4 + r;
				mask = 0;
				for (k = 0; k < 4; k++) begin
					t = r * 4 + k;
					sel = (b.color_word >> (32 + 2 * t)) & 2'h3;
					if (b.mode == MODE_DXT1) begin
						a = (punch && sel == 3) ? 0 : 8'hFF;
					end else if (b.mode == MODE_DXT3) begin
						a = ((b.alpha_word >> (4 * t)) & 4'hF) * 17;
					end else begin
						a = alut[(b.alpha_word >> (16 + 3 * t)) & 3'h7];
					end
					tx[k] = {8'(a), 8'(pal[sel][2]), 8'(pal[sel][1]), 8'(pal[sel][0])};
					if (px + k < w && py < h)
						mask |= 1 << k;
				end
				row.pixel_x = 12'(px);
				row.pixel_y = 12'(py);
				row.texel_0 = tx[0];
				row.texel_1 = tx[1];
				row.texel_2 = tx[2];
				row.texel_3 = tx[3];
				row.write_mask = 4'(mask);
				row.last_row = (r == 3);
				rows_due.push_back(row);
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_row(bc_row_t got);
			bc_row_t want;
			if (rows_due.size() == 0) begin
				$error("row result 0x%0h arrived with no row expected", got);
				errors++;
				return;
			end
			want = rows_due.pop_front();
			compare_field("pixel_x", want.pixel_x, got.pixel_x);
			compare_field("pixel_y", want.pixel_y, got.pixel_y);
			compare_field("texel_0", want.texel_0, got.texel_0);
			compare_field("texel_1", want.texel_1, got.texel_1);
			compare_field("texel_2", want.texel_2, got.texel_2);
			compare_field("texel_3", want.texel_3, got.texel_3);
			compare_field("write_mask", want.write_mask, got.write_mask);
			compare_field("last_row", want.last_row, got.last_row);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 blk_valid;
	logic                 blk_stall;
	bc_blk_t              blk_data;
	logic                 row_valid;
	logic                 row_stall;
	bc_row_t              row_data;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [BC_ADDR_W-1:0] paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	texel_row_tracker tracker = new();
	bit quiet = 1'b0;
	int cycle_count = 0;

	bc1_bc2_bc3_block_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_stall (blk_stall),
		.blk_data  (blk_data),
		.row_valid (row_valid),
		.row_stall (row_stall),
		.row_data  (row_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && blk_valid && !blk_stall)
			tracker.add_block(blk_data);
		if (arst_n && row_valid && !row_stall)
			tracker.check_row(row_data);
	end

	// The row side holds off in short bursts unless the run is in a quiet stretch.
	initial begin
		row_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				row_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			row_stall <= 1'b0;
		end
	end

	task automatic send_block(input bc_blk_t b);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			blk_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		blk_valid <= 1'b1;
		blk_data <= b;
		@(posedge clk);
		while (blk_stall) @(posedge clk);
	endtask

	task automatic drain();
		blk_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BC_ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.set_dim(idx, val);
		@(posedge clk);
	endtask

	task automatic set_image(input logic [31:0] w, input logic [31:0] h);
		drain();
		apb_write(REG_WIDTH, w);
		apb_write(REG_HEIGHT, h);
	endtask

	function automatic bc_blk_t make_block(logic [1:0] mode, int col, int row,
			logic [63:0] aw, logic [63:0] cw);
		bc_blk_t b;
		b.mode = mode;
		b.block_col = 10'(col);
		b.block_row = 10'(row);
		b.alpha_word = aw;
		b.color_word = cw;
		return b;
	endfunction

	// Picks a block index just around the image edge so that masks come out partial.
	function automatic logic [9:0] near_edge(int unsigned dim);
		int c;
		if (dim > BC_MAX_DIM)
			dim = BC_MAX_DIM;
		c = int'(dim / 4) + int'($urandom_range(0, 2)) - 1;
		if (c < 0)
			c = 0;
		if (c > 1023)
			c = 1023;
		return 10'(c);
	endfunction

	function automatic bc_blk_t random_block();
		bc_blk_t b;
		b.alpha_word = {$urandom, $urandom};
		b.color_word = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0, 1: b.mode = MODE_DXT1;
			2, 3: b.mode = MODE_DXT3;
			7: b.mode = MODE_SPARE;
			default: b.mode = MODE_DXT5;
		endcase
		if ($urandom_range(0, 2) == 0) begin
			b.block_col = 10'($urandom_range(0, 1023));
			b.block_row = 10'($urandom_range(0, 1023));
		end else begin
			b.block_col = near_edge(tracker.img_w);
			b.block_row = near_edge(tracker.img_h);
		end
		if ($urandom_range(0, 7) == 0)
			b.color_word[31:16] = b.color_word[15:0];
		if ($urandom_range(0, 7) == 0)
			b.alpha_word[15:8] = b.alpha_word[7:0];
		return b;
	endfunction

	function automatic logic [31:0] random_dim();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 5))
			0: v[12:0] = 13'd0;
			1: v[12:0] = 13'h1FFF;
			2: v[12:0] = 13'($urandom_range(1, 16));
			3: v[12:0] = 13'($urandom_range(4097, 8190));
			default: v[12:0] = 13'($urandom_range(1, 4096));
		endcase
		return v;
	endfunction

	initial begin
		int p, n;
		logic [63:0] ramp5;
		ramp5 = {48'hFAC688FAC688, 16'h0000};
		arst_n = 1'b0;
		blk_valid = 1'b0;
		blk_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset dimensions: only block (0,0) lies inside the image.
		send_block(make_block(MODE_DXT1, 0, 0, 64'h0, {32'hE4E4E4E4, 16'h001F, 16'hF800}));
		send_block(make_block(MODE_DXT1, 0, 0, '1, {32'h1B1B1B1B, 16'hFFFF, 16'h0000}));
		send_block(make_block(MODE_DXT1, 0, 0, 64'h0, {32'hFFFFFFFF, 16'h7BEF, 16'h7BEF}));
		send_block(make_block(MODE_DXT3, 0, 0, 64'hFEDCBA9876543210,
			{32'h1B1BE4E4, 16'hF800, 16'h001F}));
		send_block(make_block(MODE_DXT5, 0, 0, ramp5 | 64'h10F0,
			{32'hE4E4E4E4, 16'h0000, 16'hFFFF}));
		send_block(make_block(MODE_DXT5, 0, 0, ramp5 | 64'hF010,
			{32'hE4E41B1B, 16'hFFFF, 16'h0000}));
		send_block(make_block(MODE_DXT5, 0, 0, ramp5 | 64'h8080,
			{32'h1BE41BE4, 16'h1234, 16'hABCD}));
		send_block(make_block(MODE_SPARE, 0, 0, ramp5 | 64'h10F0,
			{32'hE4E4E4E4, 16'h0000, 16'hFFFF}));
		send_block(make_block(MODE_DXT1, 0, 0, 64'h0, 64'h0));
		send_block(make_block(MODE_DXT3, 0, 0, '1, '1));
		send_block(make_block(MODE_DXT5, 0, 0, '1, '1));
		send_block(make_block(MODE_DXT1, 0, 0, '1, '1));
		send_block(make_block(MODE_DXT1, 1, 0, {$urandom, $urandom}, {$urandom, $urandom}));
		send_block(make_block(MODE_DXT3, 0, 1, {$urandom, $urandom}, {$urandom, $urandom}));
		send_block(make_block(MODE_DXT5, 1023, 1023, ramp5 | 64'hF010, '1));

		set_image(32'd4096, 32'd4096);
		send_block(make_block(MODE_DXT3, 1023, 1023, {$urandom, $urandom}, {$urandom, $urandom}));
		send_block(make_block(MODE_DXT1, 1023, 0, {$urandom, $urandom}, {$urandom, $urandom}));
		// Values above the maximum saturate.
		set_image(32'd8191, 32'd8191);
		send_block(make_block(MODE_DXT5, 1023, 1023, {$urandom, $urandom}, {$urandom, $urandom}));
		// A zero dimension clips every pixel.
		set_image(32'd0, 32'd4);
		send_block(make_block(MODE_DXT1, 0, 0, {$urandom, $urandom}, {$urandom, $urandom}));
		set_image(32'd4, 32'd0);
		send_block(make_block(MODE_DXT3, 0, 0, {$urandom, $urandom}, {$urandom, $urandom}));
		set_image(32'd6, 32'd3);
		send_block(make_block(MODE_DXT5, 1, 0, {$urandom, $urandom}, {$urandom, $urandom}));
		send_block(make_block(MODE_DXT1, 0, 0, {$urandom, $urandom}, {$urandom, $urandom}));
		set_image(32'd1, 32'd1);
		send_block(make_block(MODE_DXT3, 0, 0, {$urandom, $urandom}, {$urandom, $urandom}));

		for (p = 0; p < 5; p++) begin
			set_image(random_dim(), random_dim());
			quiet = (p == 2 || p == 4);
			for (n = 0; n < 21; n++)
				send_block(random_block());
		end

		drain();
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
